### design/atpr_pkg.sv
// Shared types, constants and helper functions for the affine transform block.
// Used by every module of the block; depends on nothing else.
package atpr_pkg;

    // Command codes
    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_SIZE  = 2'd1;
    localparam logic [1:0] CMD_RECT  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

    // Q16.16 one, and the rounding bias added before the right shift
    localparam logic signed [31:0] Q_ONE  = 32'sd65536;
    localparam logic signed [65:0] Q_HALF = 66'sd32768;
    localparam logic signed [31:0] Q_MAX  = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN  = 32'sh80000000;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_p64;
    typedef logic signed [65:0] t_s66;

    // Transform matrix held in configuration
    typedef struct packed {
        t_q coef_a;
        t_q coef_b;
        t_q coef_c;
        t_q coef_d;
        t_q offset_x;
        t_q offset_y;
    } t_cfg;

    // Input request
    typedef struct packed {
        logic [1:0] command;
        t_q         in_x;
        t_q         in_y;
        t_q         in_w;
        t_q         in_h;
    } t_in;

    // Result
    typedef struct packed {
        t_q out_x;
        t_q out_y;
        t_q out_w;
        t_q out_h;
    } t_out;

    // Operands: near corner (or size) and saturated far corner
    typedef struct packed {
        logic [1:0] cmd;
        t_q         x0;
        t_q         y0;
        t_q         x1;
        t_q         y1;
    } t_ops;

    // The eight products; index 0 is the near coordinate, 1 the far one
    typedef struct packed {
        logic [1:0]     cmd;
        t_p64 [1:0]     p_ax;
        t_p64 [1:0]     p_cy;
        t_p64 [1:0]     p_bx;
        t_p64 [1:0]     p_dy;
    } t_prod;

    // Biased product sums per corner; bit 0 of the corner index picks x, bit 1 picks y
    typedef struct packed {
        logic [1:0]     cmd;
        t_s66 [3:0]     sx;
        t_s66 [3:0]     sy;
    } t_sum;

    // Mapped corners
    typedef struct packed {
        logic [1:0]     cmd;
        t_q [3:0]       cx;
        t_q [3:0]       cy;
    } t_corner;

    // Bounds of the mapped corners, plus the first corner for point and size
    typedef struct packed {
        logic [1:0] cmd;
        t_q         px;
        t_q         py;
        t_q         lox;
        t_q         hix;
        t_q         loy;
        t_q         hiy;
    } t_bound;

    // Saturate a 33-bit signed value to 32 bits.
    function automatic t_q sat33(input logic signed [32:0] v);
        t_q r;
        if (v[32] != v[31]) begin
            r = v[32] ? Q_MIN : Q_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Saturate a 66-bit signed value to 32 bits.
    function automatic t_q sat66(input t_s66 v);
        t_q r;
        if ((&v[65:31]) || !(|v[65:31])) begin
            r = v[31:0];
        end else begin
            r = v[65] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic t_q min2(input t_q p, input t_q q);
        return ($signed(p) < $signed(q)) ? p : q;
    endfunction

    function automatic t_q max2(input t_q p, input t_q q);
        return ($signed(p) > $signed(q)) ? p : q;
    endfunction

endpackage

### design/affine_transform_point_rect_top.sv
// Affine transform of a point, a size or a rectangle with bounding box, Q16.16.
// Throughput: one request per cycle; six register stages (operands, products,
// sums, rounding, bounds, output) each stall only on their own downstream ready.
// Reset (synchronous, active low) empties the pipeline and sets the identity matrix.
// Depends on atpr_pkg, atpr_prep, atpr_mul, atpr_dot and atpr_box.
module affine_transform_point_rect_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [atpr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  atpr_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output atpr_pkg::t_out                    o_out_data
);

    atpr_pkg::t_cfg     r_cfg;
    logic               ops_vld;
    logic               ops_rdy;
    atpr_pkg::t_ops     ops;
    logic               prod_vld;
    logic               prod_rdy;
    atpr_pkg::t_prod    prod;
    logic               crn_vld;
    logic               crn_rdy;
    atpr_pkg::t_corner  crn;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a   <= atpr_pkg::Q_ONE;
            r_cfg.coef_b   <= '0;
            r_cfg.coef_c   <= '0;
            r_cfg.coef_d   <= atpr_pkg::Q_ONE;
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                atpr_pkg::REG_COEF_A:   r_cfg.coef_a   <= i_cfg_data;
                atpr_pkg::REG_COEF_B:   r_cfg.coef_b   <= i_cfg_data;
                atpr_pkg::REG_COEF_C:   r_cfg.coef_c   <= i_cfg_data;
                atpr_pkg::REG_COEF_D:   r_cfg.coef_d   <= i_cfg_data;
                atpr_pkg::REG_OFFSET_X: r_cfg.offset_x <= i_cfg_data;
                atpr_pkg::REG_OFFSET_Y: r_cfg.offset_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Operand stage
    atpr_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (ops_vld),
        .i_ready (ops_rdy),
        .o_data  (ops)
    );

    // Multiplier stage
    atpr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (ops_vld),
        .o_ready (ops_rdy),
        .i_data  (ops),
        .o_valid (prod_vld),
        .i_ready (prod_rdy),
        .o_data  (prod)
    );

    // Sum and rounding stages
    atpr_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (prod_vld),
        .o_ready (prod_rdy),
        .i_data  (prod),
        .o_valid (crn_vld),
        .i_ready (crn_rdy),
        .o_data  (crn)
    );

    // Bounds and output stages
    atpr_box u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (crn_vld),
        .o_ready (crn_rdy),
        .i_data  (crn),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // The pipeline is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // A free output side never holds back a new request.
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_ready && !o_in_ready) |-> 1'b0)
        else $error("input stalled while the output side is ready");

    // Configuration reset gives the identity matrix.
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cfg.coef_a == atpr_pkg::Q_ONE && r_cfg.coef_d == atpr_pkg::Q_ONE
                      && r_cfg.coef_b == '0 && r_cfg.coef_c == '0))
        else $error("matrix not identity after reset");

endmodule

### design/atpr_prep.sv
// Operand stage: picks the near coordinates and forms the saturated far corner.
// Depends on atpr_pkg.
module atpr_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  atpr_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output atpr_pkg::t_ops    o_data
);

    logic             r_vld;
    atpr_pkg::t_ops   r_ops;
    atpr_pkg::t_ops   n_ops;

    assign o_ready = !r_vld || i_ready;

    // A size request uses the width and height in place of the point.
    always_comb begin
        n_ops.cmd = i_data.command;
        if (i_data.command == atpr_pkg::CMD_SIZE) begin
            n_ops.x0 = i_data.in_w;
            n_ops.y0 = i_data.in_h;
        end else begin
            n_ops.x0 = i_data.in_x;
            n_ops.y0 = i_data.in_y;
        end
        n_ops.x1 = atpr_pkg::sat33({i_data.in_x[31], i_data.in_x}
                                   + {i_data.in_w[31], i_data.in_w});
        n_ops.y1 = atpr_pkg::sat33({i_data.in_y[31], i_data.in_y}
                                   + {i_data.in_h[31], i_data.in_h});
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ops <= n_ops;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_ops;

endmodule

### design/atpr_mul.sv
// Multiplier stage: the eight 32x32 products of matrix and corner coordinates.
// Depends on atpr_pkg.
module atpr_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atpr_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  atpr_pkg::t_ops    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output atpr_pkg::t_prod   o_data
);

    logic             r_vld;
    atpr_pkg::t_prod  r_prod;
    atpr_pkg::t_prod  n_prod;

    assign o_ready = !r_vld || i_ready;

    // Each product is exact in 64 bits.
    always_comb begin
        n_prod.cmd     = i_data.cmd;
        n_prod.p_ax[0] = $signed(i_cfg.coef_a) * $signed(i_data.x0);
        n_prod.p_ax[1] = $signed(i_cfg.coef_a) * $signed(i_data.x1);
        n_prod.p_cy[0] = $signed(i_cfg.coef_c) * $signed(i_data.y0);
        n_prod.p_cy[1] = $signed(i_cfg.coef_c) * $signed(i_data.y1);
        n_prod.p_bx[0] = $signed(i_cfg.coef_b) * $signed(i_data.x0);
        n_prod.p_bx[1] = $signed(i_cfg.coef_b) * $signed(i_data.x1);
        n_prod.p_dy[0] = $signed(i_cfg.coef_d) * $signed(i_data.y0);
        n_prod.p_dy[1] = $signed(i_cfg.coef_d) * $signed(i_data.y1);
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_prod;

endmodule

### design/atpr_dot.sv
// Two stages that sum product pairs per corner, round to Q16.16, add the
// translation and saturate. Depends on atpr_pkg.
module atpr_dot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  atpr_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  atpr_pkg::t_prod    i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output atpr_pkg::t_corner  o_data
);

    logic               r_vld_a;
    logic               r_vld_b;
    logic               ready_b;
    atpr_pkg::t_sum     r_sum;
    atpr_pkg::t_sum     n_sum;
    atpr_pkg::t_corner  r_crn;
    atpr_pkg::t_corner  n_crn;
    atpr_pkg::t_q       tx;
    atpr_pkg::t_q       ty;

    assign ready_b = !r_vld_b || i_ready;
    assign o_ready = !r_vld_a || ready_b;

    // First stage: both products of a corner plus the rounding bias.
    always_comb begin
        n_sum.cmd = i_data.cmd;
        for (int k = 0; k < 4; k++) begin
            n_sum.sx[k] = {{2{i_data.p_ax[k % 2][63]}}, i_data.p_ax[k % 2]}
                        + {{2{i_data.p_cy[k / 2][63]}}, i_data.p_cy[k / 2]}
                        + atpr_pkg::Q_HALF;
            n_sum.sy[k] = {{2{i_data.p_bx[k % 2][63]}}, i_data.p_bx[k % 2]}
                        + {{2{i_data.p_dy[k / 2][63]}}, i_data.p_dy[k / 2]}
                        + atpr_pkg::Q_HALF;
        end
    end

    // A size maps by the linear part only, so it gets no translation.
    assign tx = (r_sum.cmd == atpr_pkg::CMD_SIZE) ? '0 : i_cfg.offset_x;
    assign ty = (r_sum.cmd == atpr_pkg::CMD_SIZE) ? '0 : i_cfg.offset_y;

    // Second stage: drop the fraction, add the translation, saturate.
    // Both operands are signed so that the shift keeps the sign.
    always_comb begin
        n_crn.cmd = r_sum.cmd;
        for (int k = 0; k < 4; k++) begin
            n_crn.cx[k] = atpr_pkg::sat66(($signed(r_sum.sx[k]) >>> 16)
                                          + $signed({{34{tx[31]}}, tx}));
            n_crn.cy[k] = atpr_pkg::sat66(($signed(r_sum.sy[k]) >>> 16)
                                          + $signed({{34{ty[31]}}, ty}));
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (o_ready) begin
                r_vld_a <= i_valid;
            end
            if (ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sum <= n_sum;
        end
        if (r_vld_a && ready_b) begin
            r_crn <= n_crn;
        end
    end

    assign o_valid = r_vld_b;
    assign o_data  = r_crn;

endmodule

### design/atpr_box.sv
// Two stages that find the bounds of the mapped corners and build the result
// for each command. The second stage is the output register. Depends on atpr_pkg.
module atpr_box (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  atpr_pkg::t_corner  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output atpr_pkg::t_out     o_data
);

    logic               r_vld_a;
    logic               r_vld_b;
    logic               ready_b;
    atpr_pkg::t_bound   r_bnd;
    atpr_pkg::t_bound   n_bnd;
    atpr_pkg::t_out     r_out;
    atpr_pkg::t_out     n_out;
    logic [1:0]         r_cmd;

    assign ready_b = !r_vld_b || i_ready;
    assign o_ready = !r_vld_a || ready_b;

    // First stage: minimum and maximum over the four corners.
    always_comb begin
        n_bnd.cmd = i_data.cmd;
        n_bnd.px  = i_data.cx[0];
        n_bnd.py  = i_data.cy[0];
        n_bnd.lox = atpr_pkg::min2(atpr_pkg::min2(i_data.cx[0], i_data.cx[1]),
                                   atpr_pkg::min2(i_data.cx[2], i_data.cx[3]));
        n_bnd.hix = atpr_pkg::max2(atpr_pkg::max2(i_data.cx[0], i_data.cx[1]),
                                   atpr_pkg::max2(i_data.cx[2], i_data.cx[3]));
        n_bnd.loy = atpr_pkg::min2(atpr_pkg::min2(i_data.cy[0], i_data.cy[1]),
                                   atpr_pkg::min2(i_data.cy[2], i_data.cy[3]));
        n_bnd.hiy = atpr_pkg::max2(atpr_pkg::max2(i_data.cy[0], i_data.cy[1]),
                                   atpr_pkg::max2(i_data.cy[2], i_data.cy[3]));
    end

    // Second stage: box extent and the per-command selection of fields.
    always_comb begin
        n_out = '0;
        case (r_bnd.cmd)
            atpr_pkg::CMD_POINT: begin
                n_out.out_x = r_bnd.px;
                n_out.out_y = r_bnd.py;
            end
            atpr_pkg::CMD_SIZE: begin
                n_out.out_w = r_bnd.px;
                n_out.out_h = r_bnd.py;
            end
            atpr_pkg::CMD_RECT: begin
                n_out.out_x = r_bnd.lox;
                n_out.out_y = r_bnd.loy;
                n_out.out_w = atpr_pkg::sat33({r_bnd.hix[31], r_bnd.hix}
                                              - {r_bnd.lox[31], r_bnd.lox});
                n_out.out_h = atpr_pkg::sat33({r_bnd.hiy[31], r_bnd.hiy}
                                              - {r_bnd.loy[31], r_bnd.loy});
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (o_ready) begin
                r_vld_a <= i_valid;
            end
            if (ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    // Stage payloads; the command follows the result for checking.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_bnd <= n_bnd;
        end
        if (r_vld_a && ready_b) begin
            r_out <= n_out;
            r_cmd <= r_bnd.cmd;
        end
    end

    assign o_valid = r_vld_b;
    assign o_data  = r_out;

    // A point result carries no extent.
    a_point_no_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && r_cmd == atpr_pkg::CMD_POINT) |-> (r_out.out_w == '0 && r_out.out_h == '0))
        else $error("point result has a non-zero extent");

    // A size result carries no position.
    a_size_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && r_cmd == atpr_pkg::CMD_SIZE) |-> (r_out.out_x == '0 && r_out.out_y == '0))
        else $error("size result has a non-zero position");

    // A bounding box never has a negative extent.
    a_box_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && r_cmd == atpr_pkg::CMD_RECT) |-> (!r_out.out_w[31] && !r_out.out_h[31]))
        else $error("bounding box extent is negative");

    // The bounds stage keeps minimum at or below maximum.
    a_bound_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_a |-> ($signed(r_bnd.lox) <= $signed(r_bnd.hix)
                     && $signed(r_bnd.loy) <= $signed(r_bnd.hiy)))
        else $error("corner bounds out of order");

endmodule
